// ----- hw/rtl/tsp_pkg.sv -----
package tsp_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 3;

  // Column count reaches the width itself; row count runs up to height + 2
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
  localparam int ADDR_W = $clog2(MAX_WIDTH);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(160);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(120);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBPASS = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2
  } cfg_reg_t;

  // Input word
  typedef struct packed {
    logic action;
    logic pixel_in;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic pixel_out;
    logic frame_last;
  } out_word_t;

  // One window column: bit 0 upper row, bit 1 middle row, bit 2 lower row
  typedef logic [2:0] column_t;

  // Zhang-Suen keep/clear decision for the center of a 3x3 window.
  // Window layout: left column bits 2:0, middle 5:3, right 8:6.
  function automatic logic thin_center(logic [8:0] win, logic subpass);
    logic [7:0] p;
    logic [3:0] a;
    logic [3:0] b;
    logic       m1;
    logic       m2;
    p[0] = win[3]; // N
    p[1] = win[6]; // NE
    p[2] = win[7]; // E
    p[3] = win[8]; // SE
    p[4] = win[5]; // S
    p[5] = win[2]; // SW
    p[6] = win[1]; // W
    p[7] = win[0]; // NW
    a = '0;
    b = '0;
    for (int k = 0; k < 8; k++) begin
      b = b + 4'(p[k]);
      if (!p[k] && p[3'(k + 1)]) begin
        a = a + 4'd1;
      end
    end
    if (subpass) begin
      m1 = p[0] & p[2] & p[6];
      m2 = p[0] & p[4] & p[6];
    end else begin
      m1 = p[0] & p[2] & p[4];
      m2 = p[2] & p[4] & p[6];
    end
    if (!win[4]) begin
      return 1'b0;
    end
    if (a == 4'd1 && b >= 4'd2 && b <= 4'd6 && !m1 && !m2) begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

endpackage

// ----- hw/rtl/tsp_line_store.sv -----
module tsp_line_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [tsp_pkg::ADDR_W-1:0] rd_addr,
  output logic [1:0]                rd_data,
  input  logic                      wr_en,
  input  logic [tsp_pkg::ADDR_W-1:0] wr_addr,
  input  logic [1:0]                wr_data
);
  import tsp_pkg::*;

  // Both line stores side by side: bit 1 upper row, bit 0 middle row
  logic [1:0] mem [MAX_WIDTH];

  // Registered read, holds while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- hw/rtl/tsp_col_cell.sv -----
module tsp_col_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             zero,
  input  tsp_pkg::column_t din,
  output tsp_pkg::column_t col
);
  import tsp_pkg::*;

  // One window column; takes its neighbor's column on every shift unless zero clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (en) begin
      col <= zero ? column_t'(0) : din;
    end
  end

endmodule

// ----- hw/rtl/thinning_subpass_filter.sv -----
// Channel | Dir | Handshake           | Word
// in      | in  | in_valid/in_ready   | in_word  (action, pixel_in)
// out     | out | out_valid/out_ready | out_word (pixel_out, frame_last)
// cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// One pixel per clock sustained while out_ready holds; an accepted pixel passes
// the line store read register, then the output register, on its way to out_word.
// The line store's single read port takes one read per accepted word.
// Reset clears counters, window and handshake state; line stores start unknown
// and their data is only used once the rows above have been written.
// A stalled output holds one word while the next pixel can still be taken.
module thinning_subpass_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tsp_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tsp_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsp_pkg::*;

  // Configuration, sizes held already clamped
  logic             subpass;
  logic [COL_W-1:0] width_eff;
  logic [ROW_W-1:0] height_eff;

  // Position of the next input pixel
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;

  // Input stage decode
  logic [COL_W-1:0] a_c1;
  logic [ROW_W-1:0] a_r1;
  logic [COL_W-1:0] a_c;
  logic [ROW_W-1:0] a_r;
  logic [COL_W-1:0] a_c_inc;
  logic [ROW_W-1:0] h_p1;
  logic             a_restart;
  logic             a_pix;
  logic             a_emit;
  logic             a_last;
  logic             accept;

  // Window stage
  logic              b_valid;
  logic [ADDR_W-1:0] b_addr;
  logic              b_pix;
  logic              b_r_ge1;
  logic              b_r_ge2;
  logic              b_emit;
  logic              b_last;
  logic              b_cz;
  logic              b_clr;
  logic              b_go;
  logic [1:0]        rd_data;
  logic              up;
  logic              mid;
  column_t           newcol;
  column_t           col_l;
  column_t           col_m;
  column_t           col_r;
  logic [8:0]        center;

  // Config writes with clamping
  always_ff @(posedge clk) begin
    if (rst) begin
      subpass    <= 1'b0;
      width_eff  <= WIDTH_RESET;
      height_eff <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SUBPASS: subpass <= cfg_data[0];
        REG_WIDTH: begin
          if (cfg_data < CFG_DATA_W'(MIN_SIZE)) begin
            width_eff <= COL_W'(MIN_SIZE);
          end else if (int'(cfg_data) > MAX_WIDTH) begin
            width_eff <= COL_W'(MAX_WIDTH);
          end else begin
            width_eff <= COL_W'(cfg_data);
          end
        end
        REG_HEIGHT: begin
          if (cfg_data < CFG_DATA_W'(MIN_SIZE)) begin
            height_eff <= ROW_W'(MIN_SIZE);
          end else if (int'(cfg_data) > MAX_HEIGHT) begin
            height_eff <= ROW_W'(MAX_HEIGHT);
          end else begin
            height_eff <= ROW_W'(cfg_data);
          end
        end
        default: ;
      endcase
    end
  end

  // Position decode: wrap an overlong row, restart past the drain
  always_comb begin
    h_p1 = height_eff + ROW_W'(1);
    a_c1 = col;
    a_r1 = row;
    if (col >= width_eff) begin
      a_c1 = '0;
      a_r1 = row + ROW_W'(1);
    end
    a_restart = (a_r1 > h_p1) || (a_r1 == h_p1 && a_c1 != '0);
    a_c = a_restart ? '0 : a_c1;
    a_r = a_restart ? '0 : a_r1;
    a_c_inc = a_c + COL_W'(1);
    a_pix  = !in_word.action && (a_r < height_eff) && in_word.pixel_in;
    a_emit = (a_r >= ROW_W'(2)) || (a_r == ROW_W'(1) && a_c != '0);
    a_last = (a_r == h_p1) && (a_c == '0);
    if (a_last) begin
      col_next = '0;
      row_next = '0;
    end else if (a_c_inc >= width_eff) begin
      col_next = '0;
      row_next = a_r + ROW_W'(1);
    end else begin
      col_next = a_c_inc;
      row_next = a_r;
    end
  end

  assign b_go     = b_valid && (!out_valid || out_ready);
  assign in_ready = !b_valid || b_go;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Window stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_addr  <= a_c[ADDR_W-1:0];
      b_pix   <= a_pix;
      b_r_ge1 <= (a_r >= ROW_W'(1));
      b_r_ge2 <= (a_r >= ROW_W'(2));
      b_emit  <= a_emit;
      b_last  <= a_last;
      b_cz    <= (a_c == '0);
      b_clr   <= a_restart;
    end
  end

  tsp_line_store u_lines (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (a_c[ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (b_go),
    .wr_addr (b_addr),
    .wr_data ({mid, b_pix})
  );

  // New right column from the line stores and the incoming pixel
  always_comb begin
    up     = b_r_ge2 & rd_data[1];
    mid    = b_r_ge1 & rd_data[0];
    newcol = {b_pix, mid, up};
    center = b_clr ? 9'd0 : {(b_cz ? column_t'(0) : newcol), col_r, col_m};
  end

  // Window columns shift right to left
  tsp_col_cell u_cell_l (
    .clk  (clk),
    .rst  (rst),
    .en   (b_go),
    .zero (b_cz || b_last),
    .din  (col_m),
    .col  (col_l)
  );

  tsp_col_cell u_cell_m (
    .clk  (clk),
    .rst  (rst),
    .en   (b_go),
    .zero (b_cz || b_last),
    .din  (col_r),
    .col  (col_m)
  );

  tsp_col_cell u_cell_r (
    .clk  (clk),
    .rst  (rst),
    .en   (b_go),
    .zero (b_last),
    .din  (newcol),
    .col  (col_r)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_emit) begin
      out_word.pixel_out  <= thin_center(center, subpass);
      out_word.frame_last <= b_last;
    end
  end

  // Frame end empties the window
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    b_go && b_last |=> col_l == '0 && col_m == '0 && col_r == '0)
    else $error("window not cleared after frame end");

  // Row start leaves left and middle columns empty
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    b_go && b_cz |=> col_l == '0 && col_m == '0)
    else $error("stale columns at row start");

  // Last pixel sits at column zero and always produces a word
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_last |-> b_cz && b_emit)
    else $error("frame end not at column zero or not emitted");

  // A new word never lands on a word still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !b_go)
    else $error("window stage advanced into a stalled output");

endmodule

// ----- bench/thinning_subpass_filter_tb.sv -----
module thinning_subpass_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsp_pkg::*;

  // Input word action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Directed rows either carry a hand-written result or defer to the predictor
  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam int unsigned DIRECTED_LEN = 26;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned DRAIN_SLACK  = 8;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PRINT_CAP    = 200;

  typedef struct packed {
    logic action;
    logic pixel_in;
    logic typed;
    logic exp_pixel;
    logic exp_last;
  } plan_row_t;

  // 3x3 frames. First: all clear, every result readable by eye.
  // Second: all set, with an early flush inside the frame and pixels in the drain.
  localparam plan_row_t DIRECTED [DIRECTED_LEN] = '{
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_FLUSH, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_FLUSH, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_FLUSH, 1'b0, TYPED, 1'b0, 1'b0},
    '{ACT_FLUSH, 1'b0, TYPED, 1'b0, 1'b1},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_FLUSH, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_FLUSH, 1'b0, PREDICTED, 1'b0, 1'b0},
    '{ACT_PIXEL, 1'b1, PREDICTED, 1'b0, 1'b0},
    '{ACT_FLUSH, 1'b1, PREDICTED, 1'b0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: line stores, window, raster position and registers
  bit          upper_row  [MAX_WIDTH];
  bit          middle_row [MAX_WIDTH];
  logic [8:0]  win_bits   = '0;
  int unsigned col_pos    = 0;
  int unsigned row_pos    = 0;
  logic        subpass_reg = 1'b0;
  logic [10:0] width_reg   = 11'(WIDTH_RESET);
  logic [10:0] height_reg  = 11'(HEIGHT_RESET);

  out_word_t   thinned_q[$];
  bit          no_idle = 1'b0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned frames_seen = 0;
  int unsigned configs_used = 0;
  int unsigned mismatch_count = 0;

  thinning_subpass_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned hi);
    if (v < 11'd3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Zhang-Suen test on the window center; ring bit 0 is north, going clockwise
  function automatic logic survives_subpass(logic [8:0] win, logic sp);
    logic [7:0] ring;
    logic [7:0] next_ring;
    int         set_count;
    int         rises;
    logic       terms_clear;
    ring      = {win[0], win[1], win[2], win[5], win[8], win[7], win[6], win[3]};
    next_ring = {ring[0], ring[7:1]};
    set_count = $countones(ring);
    rises     = $countones(~ring & next_ring);
    // north 0, east 2, south 4, west 6
    if (sp) begin
      terms_clear = !(ring[0] & ring[2] & ring[6]) && !(ring[0] & ring[4] & ring[6]);
    end else begin
      terms_clear = !(ring[0] & ring[2] & ring[4]) && !(ring[2] & ring[4] & ring[6]);
    end
    return win[4] && !(rises == 1 && set_count >= 2 && set_count <= 6 && terms_clear);
  endfunction

  // Advance the frame by one input word; returns the thinned pixel it releases
  function automatic void predict_thinned(input in_word_t w, output bit produced,
                                          output out_word_t r);
    int unsigned wd;
    int unsigned ht;
    int unsigned rr;
    int unsigned cc;
    logic        pix;
    logic        up;
    logic        mid;
    logic [2:0]  newcol;
    logic [8:0]  center;
    bit          last;
    wd = clamp_dim(width_reg, MAX_WIDTH);
    ht = clamp_dim(height_reg, MAX_HEIGHT);
    // a shrunken width or height can leave the position out of range
    if (col_pos >= wd) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > ht + 1 || (row_pos == ht + 1 && col_pos > 0)) begin
      row_pos  = 0;
      col_pos  = 0;
      win_bits = '0;
    end
    rr = row_pos;
    cc = col_pos;

    // rows outside the frame read as zero
    pix = (w.action == ACT_PIXEL && rr < ht) ? w.pixel_in : 1'b0;
    up  = (rr >= 2) ? upper_row[cc] : 1'b0;
    mid = (rr >= 1) ? middle_row[cc] : 1'b0;
    newcol = {pix, mid, up};
    upper_row[cc]  = mid;
    middle_row[cc] = pix;

    produced = (rr >= 2) || (rr == 1 && cc >= 1);
    if (cc == 0) begin
      center   = {3'b000, win_bits[8:3]};
      win_bits = {newcol, 6'b000000};
    end else begin
      win_bits = {newcol, win_bits[8:3]};
      center   = win_bits;
    end

    last = (rr == ht + 1 && cc == 0);
    if (last) begin
      row_pos  = 0;
      col_pos  = 0;
      win_bits = '0;
    end else if (cc + 1 >= wd) begin
      col_pos = 0;
      row_pos = rr + 1;
    end else begin
      col_pos = cc + 1;
    end

    r.pixel_out  = survives_subpass(center, subpass_reg);
    r.frame_last = last;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_density();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) * 100;
    return $urandom_range(10, 90);
  endfunction

  // Mostly small sizes, some below the minimum, some a little larger
  function automatic int unsigned pick_size(int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(3, hi);
    if (roll < 90) return $urandom_range(0, 2);
    return $urandom_range(hi + 1, 3 * hi);
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SUBPASS: subpass_reg = val[0];
      REG_WIDTH:   width_reg   = 11'(val);
      REG_HEIGHT:  height_reg  = 11'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t typed_word,
                           output bit ended);
    int unsigned gap;
    bit          produced;
    out_word_t   r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_in++;
    predict_thinned(w, produced, r);
    ended = produced && r.frame_last;
    if (produced) thinned_q.insert(thinned_q.size(), typed ? typed_word : r);
    if (ended) frames_seen++;
  endtask

  // Hold off the sender until every expected word is out and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (thinned_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Raster-ordered frames with random content and a little action noise;
  // cut > 0 stops after that many words, possibly mid-frame
  task automatic run_frames(input int unsigned n_frames, input int unsigned cut);
    int unsigned sent;
    int unsigned done;
    int unsigned density;
    in_word_t    w;
    bit          ended;
    sent    = 0;
    done    = 0;
    density = pick_density();
    while (done < n_frames && (cut == 0 || sent < cut)) begin
      w.action = (row_pos < clamp_dim(height_reg, MAX_HEIGHT)) ? ACT_PIXEL : ACT_FLUSH;
      if ($urandom_range(0, 99) < 3) w.action = ~w.action;
      w.pixel_in = ($urandom_range(0, 99) < density);
      send_word(w, 1'b0, '0, ended);
      sent++;
      if (ended) begin
        done++;
        density = pick_density();
      end
    end
  endtask

  // Output side: random stalls, compare each word with the oldest expectation
  initial begin
    int unsigned hold;
    out_word_t   exp_word;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        words_out++;
        if (thinned_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP) begin
            $display("%0t: unexpected output word, expected none, got pixel_out=%0b frame_last=%0b",
                     $time, out_word.pixel_out, out_word.frame_last);
          end
        end else begin
          exp_word = thinned_q.pop_front();
          if (out_word.pixel_out !== exp_word.pixel_out) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP) begin
              $display("%0t: pixel_out expected %0b, got %0b", $time,
                       exp_word.pixel_out, out_word.pixel_out);
            end
          end
          if (out_word.frame_last !== exp_word.frame_last) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP) begin
              $display("%0t: frame_last expected %0b, got %0b", $time,
                       exp_word.frame_last, out_word.frame_last);
            end
          end
        end
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Watchdog: too many cycles without a word moving on either side
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("thinning_subpass_filter test failed");
    $finish;
  end

  // Stimulus
  initial begin
    in_word_t    w;
    out_word_t   typed_word;
    bit          ended;
    bit          mid_frame;
    int unsigned new_w;
    int unsigned new_h;
    int unsigned cut;
    int unsigned remaining;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SUBPASS;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames at the minimum size
    write_reg(REG_SUBPASS, 0);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    configs_used++;
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      w.action              = DIRECTED[i].action;
      w.pixel_in            = DIRECTED[i].pixel_in;
      typed_word.pixel_out  = DIRECTED[i].exp_pixel;
      typed_word.frame_last = DIRECTED[i].exp_last;
      send_word(w, DIRECTED[i].typed, typed_word, ended);
    end

    // random settings; a phase may end mid-frame, then the width never grows
    while (words_in < DIRECTED_LEN + RANDOM_ITEMS) begin
      wait_idle();
      no_idle   = ($urandom_range(0, 5) == 0);
      mid_frame = (row_pos != 0 || col_pos != 0);
      new_w     = pick_size(12);
      new_h     = pick_size(10);
      if (mid_frame &&
          clamp_dim(11'(new_w), MAX_WIDTH) > clamp_dim(width_reg, MAX_WIDTH)) begin
        new_w = 32'(width_reg);
      end
      write_reg(REG_SUBPASS, $urandom_range(0, 1));
      write_reg(REG_WIDTH, new_w);
      write_reg(REG_HEIGHT, new_h);
      configs_used++;
      remaining = DIRECTED_LEN + RANDOM_ITEMS - words_in;
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
      if (cut == 0 || cut > remaining) cut = remaining;
      run_frames($urandom_range(1, 3), cut);
    end

    // sizes above and below the limits, reached through clamping, starting on a frame boundary;
    // the widest row is cut short, then the width shrinks to the minimum
    if (row_pos != 0 || col_pos != 0) run_frames(1, 0);
    wait_idle();
    write_reg(REG_SUBPASS, $urandom_range(0, 1));
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_HEIGHT, 2);
    configs_used++;
    run_frames(1, 30);
    wait_idle();
    write_reg(REG_SUBPASS, $urandom_range(0, 1));
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 2047);
    configs_used++;
    run_frames(1, 40);
    wait_idle();

    $display("Sent %0d input words in %0d frames under %0d settings; checked %0d output words.",
             words_in, frames_seen, configs_used, words_out);
    $display("Both sub-passes, early flushes, drain pixels, mid-frame resizes and clamped sizes.");
    if (mismatch_count == 0) begin
      $display("thinning_subpass_filter test passed");
    end else begin
      $display("thinning_subpass_filter test failed");
    end
    $finish;
  end

endmodule

// ----- thinning_subpass_filter.f -----
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_line_store.sv
hw/rtl/tsp_col_cell.sv
hw/rtl/thinning_subpass_filter.sv
bench/thinning_subpass_filter_tb.sv
